// ===== src/lbf_pkg.sv =====
// shared types, constants and codes for the learning bridge forwarder
package lbf_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int PORT_COUNT        = 8;
    localparam logic [7:0] PORT_ALL  = 8'(((1 << PORT_COUNT) - 1) & 8'hFF);
    localparam logic [15:0] MIN_FRAME = 16'd14;
    localparam int GROUP_BIT         = 40;

    localparam logic [47:0] BRIDGE_MAC_RST   = 48'h02B1_6000_0010;
    localparam logic [23:0] AGEING_TICKS_RST = 24'd30000;

    // register indexes
    localparam logic [2:0] REG_BRIDGE_MAC   = 3'd0;
    localparam logic [2:0] REG_BRIDGE_UP    = 3'd1;
    localparam logic [2:0] REG_PORT_PRESENT = 3'd2;
    localparam logic [2:0] REG_PORT_UP      = 3'd3;
    localparam logic [2:0] REG_AGEING       = 3'd4;

    // request types
    localparam logic [1:0] REQ_RX    = 2'd0;
    localparam logic [1:0] REQ_TX    = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_FLUSH = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_FILTERED = 2'd2;
    localparam logic [1:0] ST_NET_DOWN = 2'd3;

    typedef enum logic [2:0] {
        OP_DROP,
        OP_RX,
        OP_TX,
        OP_TICK,
        OP_FLUSH
    } lbf_op_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [2:0]  in_port;
        logic [15:0] frame_len;
    } lbf_in_t;

    typedef struct packed {
        logic [7:0] forward_mask;
        logic       deliver_up;
        logic       dst_known;
        logic [1:0] status;
    } lbf_out_t;

    typedef struct packed {
        logic [47:0] bridge_mac;
        logic        bridge_up;
        logic [7:0]  port_present_mask;
        logic [7:0]  port_up_mask;
        logic [23:0] ageing_ticks;
    } lbf_cfg_t;

    // classified request passed from front to back
    typedef struct packed {
        lbf_op_t     op;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [2:0]  port;
        logic        dst_group;
        logic        dst_own;
        logic        src_learn;
    } lbf_item_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [2:0]  port;
        logic [47:0] stamp;
    } lbf_entry_t;

endpackage

// ===== src/learning_bridge_forwarder.sv =====
// learning bridge forwarder: config registers, front end and back end
// a tick or a dropped frame needs no table scan; a lookup scans the table once;
// a learning frame scans it once to learn and may scan again to look up; a flush scans it once
// the back end takes a new transaction only when idle; the table scan reads one entry a cycle
// the front queue takes up to two transactions while the back end is busy
// reset: table valid bits and time cleared at once, registers to their defaults
module learning_bridge_forwarder
    import lbf_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  lbf_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output lbf_out_t    out_data
);
    lbf_cfg_t  cfg_reg, cfg_next;
    logic      q_valid, q_ready;
    lbf_item_t q_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BRIDGE_MAC:   cfg_next.bridge_mac        = cfg_data;
                REG_BRIDGE_UP:    cfg_next.bridge_up         = cfg_data[0];
                REG_PORT_PRESENT: cfg_next.port_present_mask = cfg_data[7:0];
                REG_PORT_UP:      cfg_next.port_up_mask      = cfg_data[7:0];
                REG_AGEING:       cfg_next.ageing_ticks      = cfg_data[23:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bridge_mac        <= BRIDGE_MAC_RST;
            cfg_reg.bridge_up         <= 1'b0;
            cfg_reg.port_present_mask <= 8'd0;
            cfg_reg.port_up_mask      <= 8'd0;
            cfg_reg.ageing_ticks      <= AGEING_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lbf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    lbf_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule

// ===== src/lbf_ram.sv =====
// generic simple dual-port ram with registered read
module lbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

// ===== src/lbf_front.sv =====
// front end: accepts requests, classifies them and queues them for the back end
module lbf_front
    import lbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lbf_cfg_t  cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  lbf_in_t   in_data,
    output logic      q_valid,
    input  logic      q_ready,
    output lbf_item_t q_item
);
    lbf_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    lbf_item_t  cls;
    logic       push, pop;
    logic [7:0] pbit;

    always_comb
    begin
        pbit          = 8'(1) << in_data.in_port;
        cls.dst_mac   = in_data.dst_mac;
        cls.src_mac   = in_data.src_mac;
        cls.port      = in_data.in_port;
        cls.dst_group = in_data.dst_mac[GROUP_BIT];
        cls.dst_own   = (in_data.dst_mac == cfg.bridge_mac);
        cls.src_learn = !in_data.src_mac[GROUP_BIT] && (in_data.src_mac != 48'd0);
        case (in_data.req_type)
            REQ_RX:
            begin
                if (in_data.frame_len < MIN_FRAME || !cfg.bridge_up
                    || ((cfg.port_present_mask & PORT_ALL & pbit) == 8'd0))
                    cls.op = OP_DROP;
                else
                    cls.op = OP_RX;
            end
            REQ_TX:   cls.op = OP_TX;
            REQ_TICK: cls.op = OP_TICK;
            default:  cls.op = OP_FLUSH;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== src/lbf_back.sv =====
// back end: table scans for learning, lookup and flush, and the result register
module lbf_back
    import lbf_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  lbf_cfg_t  cfg,
    input  logic      q_valid,
    output logic      q_ready,
    input  lbf_item_t q_item,
    output logic      out_valid,
    input  logic      out_ready,
    output lbf_out_t  out_data
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW:0] LAST = (AW+1)'(TABLE_ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LSCAN  = 7'b0000010,
        S_LWRITE = 7'b0000100,
        S_KSCAN  = 7'b0001000,
        S_KDONE  = 7'b0010000,
        S_FLUSH  = 7'b0100000,
        S_RESULT = 7'b1000000
    } lbf_state_t;

    lbf_state_t state_reg, state_next;
    lbf_item_t  item_reg, item_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [47:0] time_reg, time_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic        pend_reg, pend_next;
    logic [AW-1:0] pidx_reg, pidx_next;

    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic          free_reg, free_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    logic [47:0]   best_age_reg, best_age_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic [2:0]    fport_reg, fport_next;
    logic [47:0]   fstamp_reg, fstamp_next;

    logic       out_valid_reg, out_valid_next;
    lbf_out_t   out_reg, out_next;

    logic       ram_we;
    logic [AW-1:0] ram_waddr;
    lbf_entry_t ram_wdata, ram_rdata;
    logic [$bits(lbf_entry_t)-1:0] ram_rbits;

    logic [47:0] age;
    logic        match;
    logic        scan_done;
    logic        need_lookup;
    logic [7:0]  live, pbit, obit;
    lbf_out_t    res;

    lbf_ram #(
        .WIDTH ($bits(lbf_entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rbits)
    );

    assign ram_rdata = lbf_entry_t'(ram_rbits);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign q_ready   = (state_reg == S_IDLE);

    assign scan_done   = (cnt_reg == LAST) && !pend_reg;
    assign age         = time_reg - ram_rdata.stamp;
    assign need_lookup = (item_reg.op == OP_TX) ? !item_reg.dst_group
                         : (!item_reg.dst_group && !item_reg.dst_own);
    assign live        = cfg.port_present_mask & cfg.port_up_mask & PORT_ALL;
    assign pbit        = 8'(1) << item_reg.port;
    assign obit        = 8'(1) << fport_reg;

    // final result from the request kind and the lookup outcome
    always_comb
    begin
        res = '0;
        case (item_reg.op)
            OP_DROP: res.status = ST_DROPPED;
            OP_RX:
            begin
                if (item_reg.dst_group)
                begin
                    res.forward_mask = live & ~pbit;
                    res.deliver_up   = 1'b1;
                end
                else if (item_reg.dst_own)
                    res.deliver_up = 1'b1;
                else if (!hit_reg)
                    res.forward_mask = live & ~pbit;
                else
                begin
                    res.dst_known = 1'b1;
                    if (fport_reg == item_reg.port)
                        res.status = ST_FILTERED;
                    else
                        res.forward_mask = live & obit;
                end
            end
            OP_TX:
            begin
                if (!item_reg.dst_group && hit_reg)
                begin
                    res.dst_known = 1'b1;
                    if ((live & obit) != 8'd0)
                        res.forward_mask = obit;
                    else
                        res.status = ST_NET_DOWN;
                end
                else
                begin
                    res.forward_mask = live;
                    if (live == 8'd0)
                        res.status = ST_NET_DOWN;
                end
            end
            default: res = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        valid_next     = valid_reg;
        time_next      = time_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        best_age_next  = best_age_reg;
        best_idx_next  = best_idx_reg;
        fport_next     = fport_reg;
        fstamp_next    = fstamp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : best_idx_reg);
        ram_wdata.mac   = item_reg.src_mac;
        ram_wdata.port  = item_reg.port;
        ram_wdata.stamp = time_reg;
        match = 1'b0;

        // read pipeline for the scanning states
        if (state_reg == S_LSCAN || state_reg == S_KSCAN || state_reg == S_FLUSH)
        begin
            if (cnt_reg != LAST)
            begin
                pend_next = 1'b1;
                pidx_next = cnt_reg[AW-1:0];
                cnt_next  = cnt_reg + 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                hit_next = 1'b0;
                free_next = 1'b0;
                if (q_valid)
                begin
                    item_next = q_item;
                    case (q_item.op)
                        OP_DROP: state_next = S_RESULT;
                        OP_TICK:
                        begin
                            time_next  = time_reg + 48'd1;
                            state_next = S_RESULT;
                        end
                        OP_FLUSH: state_next = S_FLUSH;
                        OP_RX:
                        begin
                            if (q_item.src_learn)
                                state_next = S_LSCAN;
                            else if (!q_item.dst_group && !q_item.dst_own)
                                state_next = S_KSCAN;
                            else
                                state_next = S_RESULT;
                        end
                        OP_TX: state_next = q_item.dst_group ? S_RESULT : S_KSCAN;
                        default: state_next = S_RESULT;
                    endcase
                end
            end
            S_LSCAN:
            begin
                if (pend_reg)
                begin
                    match = valid_reg[pidx_reg] && (ram_rdata.mac == item_reg.src_mac);
                    if (match && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = pidx_reg;
                    end
                    if (!valid_reg[pidx_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = pidx_reg;
                    end
                    // oldest stamp, lowest index on a tie
                    if (pidx_reg == '0 || age > best_age_reg)
                    begin
                        best_age_next = age;
                        best_idx_next = pidx_reg;
                    end
                end
                if (scan_done)
                    state_next = S_LWRITE;
            end
            S_LWRITE:
            begin
                ram_we = 1'b1;
                valid_next[ram_waddr] = 1'b1;
                cnt_next = '0;
                hit_next = 1'b0;
                state_next = need_lookup ? S_KSCAN : S_RESULT;
            end
            S_KSCAN:
            begin
                if (pend_reg)
                begin
                    match = valid_reg[pidx_reg] && (ram_rdata.mac == item_reg.dst_mac);
                    if (match && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = pidx_reg;
                        fport_next   = ram_rdata.port;
                        fstamp_next  = ram_rdata.stamp;
                    end
                end
                if (scan_done)
                    state_next = S_KDONE;
            end
            S_KDONE:
            begin
                // a stale entry is dropped and counts as unknown
                if (hit_reg && ((time_reg - fstamp_reg) > {24'd0, cfg.ageing_ticks}))
                begin
                    valid_next[hit_idx_reg] = 1'b0;
                    hit_next = 1'b0;
                end
                state_next = S_RESULT;
            end
            S_FLUSH:
            begin
                if (pend_reg && valid_reg[pidx_reg] && ram_rdata.port == item_reg.port)
                    valid_next[pidx_reg] = 1'b0;
                if (scan_done)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pidx_reg     <= pidx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        best_age_reg <= best_age_next;
        best_idx_reg <= best_idx_next;
        fport_reg    <= fport_next;
        fstamp_reg   <= fstamp_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            time_reg      <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            time_reg      <= time_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== src/lbf_checker.sv =====
// port-level checks for the learning bridge forwarder, bound to the top level
module lbf_checker
    import lbf_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input lbf_out_t out_data
);
    // an offered result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed before it was taken");

    // a dropped frame carries nothing else
    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_DROPPED |->
            out_data.forward_mask == 8'd0 && !out_data.deliver_up && !out_data.dst_known)
        else $error("dropped frame with non-zero fields");

    // filtering only happens on a known destination and sends nothing
    a_filter_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_FILTERED |->
            out_data.dst_known && out_data.forward_mask == 8'd0)
        else $error("filtered result without known destination");

    // upward delivery only with a completed received frame
    a_up_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.deliver_up |->
            out_data.status == ST_DONE && !out_data.dst_known)
        else $error("deliver up with bad status");
endmodule

bind learning_bridge_forwarder lbf_checker u_lbf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== dv/tb_learning_bridge_forwarder.sv =====
// self-checking testbench for the learning bridge forwarder
`timescale 1ns / 1ps

module tb_learning_bridge_forwarder;
    import lbf_pkg::*;

    localparam int ENTRIES   = 64;
    localparam int WDOG_MAX  = 20000;

    class bridge_scoreboard;
        logic [47:0] own_mac;
        logic        up;
        logic [7:0]  present;
        logic [7:0]  port_up;
        logic [23:0] ageing;
        logic        valid_q [ENTRIES];
        logic [47:0] mac_q   [ENTRIES];
        logic [2:0]  port_q  [ENTRIES];
        logic [47:0] stamp_q [ENTRIES];
        logic [47:0] now;
        lbf_out_t    pending [$];
        int          errors;

        function new();
            own_mac = BRIDGE_MAC_RST;
            up = 1'b0;
            present = '0;
            port_up = '0;
            ageing = AGEING_TICKS_RST;
            now = '0;
            errors = 0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_q[i] = 1'b0;
                mac_q[i] = '0;
                port_q[i] = '0;
                stamp_q[i] = '0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] val);
            case (idx)
                REG_BRIDGE_MAC:   own_mac = val;
                REG_BRIDGE_UP:    up = val[0];
                REG_PORT_PRESENT: present = val[7:0];
                REG_PORT_UP:      port_up = val[7:0];
                REG_AGEING:       ageing = val[23:0];
                default: ;
            endcase
        endfunction

        function logic [47:0] age(int i);
            return now - stamp_q[i];
        endfunction

        function void learn_src(logic [47:0] src, logic [2:0] p);
            int victim;
            victim = -1;
            if (src[GROUP_BIT] || src == 0)
                return;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_q[i] && mac_q[i] == src)
                begin
                    port_q[i] = p;
                    stamp_q[i] = now;
                    return;
                end
                if (!valid_q[i] && victim < 0)
                    victim = i;
            end
            if (victim < 0)
            begin
                victim = 0;
                for (int i = 1; i < ENTRIES; i++)
                    if (age(i) > age(victim))
                        victim = i;
            end
            mac_q[victim] = src;
            port_q[victim] = p;
            stamp_q[victim] = now;
            valid_q[victim] = 1'b1;
        endfunction

        // stale hits are invalidated on the way
        function bit find_dst(logic [47:0] dst, output logic [2:0] p);
            p = '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!valid_q[i] || mac_q[i] != dst)
                    continue;
                if (age(i) > {24'd0, ageing})
                begin
                    valid_q[i] = 1'b0;
                    return 0;
                end
                p = port_q[i];
                return 1;
            end
            return 0;
        endfunction

        function void note_request(lbf_in_t t);
            lbf_out_t r;
            logic [7:0] live, pbit, outbit;
            logic [2:0] outp;
            r = '0;
            live = present & port_up & PORT_ALL;
            pbit = 8'd1 << t.in_port;
            case (t.req_type)
                REQ_RX:
                begin
                    if (t.frame_len < MIN_FRAME || !up || !(present & PORT_ALL & pbit))
                        r.status = ST_DROPPED;
                    else
                    begin
                        learn_src(t.src_mac, t.in_port);
                        if (t.dst_mac[GROUP_BIT])
                        begin
                            r.forward_mask = live & ~pbit;
                            r.deliver_up = 1'b1;
                        end
                        else if (t.dst_mac == own_mac)
                            r.deliver_up = 1'b1;
                        else if (!find_dst(t.dst_mac, outp))
                            r.forward_mask = live & ~pbit;
                        else
                        begin
                            r.dst_known = 1'b1;
                            outbit = 8'd1 << outp;
                            if (outp == t.in_port)
                                r.status = ST_FILTERED;
                            else
                                r.forward_mask = live & outbit;
                        end
                    end
                end
                REQ_TX:
                begin
                    if (!t.dst_mac[GROUP_BIT] && find_dst(t.dst_mac, outp))
                    begin
                        r.dst_known = 1'b1;
                        outbit = 8'd1 << outp;
                        if (live & outbit)
                            r.forward_mask = outbit;
                        else
                            r.status = ST_NET_DOWN;
                    end
                    else
                    begin
                        r.forward_mask = live;
                        if (live == 0)
                            r.status = ST_NET_DOWN;
                    end
                end
                REQ_TICK:
                    now = now + 48'd1;
                default:
                    for (int i = 0; i < ENTRIES; i++)
                        if (valid_q[i] && port_q[i] == t.in_port)
                            valid_q[i] = 1'b0;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(lbf_out_t got);
            lbf_out_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.forward_mask !== exp_r.forward_mask)
            begin
                $error("forward_mask exp %h got %h", exp_r.forward_mask, got.forward_mask);
                errors++;
            end
            if (got.deliver_up !== exp_r.deliver_up)
            begin
                $error("deliver_up exp %b got %b", exp_r.deliver_up, got.deliver_up);
                errors++;
            end
            if (got.dst_known !== exp_r.dst_known)
            begin
                $error("dst_known exp %b got %b", exp_r.dst_known, got.dst_known);
                errors++;
            end
            if (got.status !== exp_r.status)
            begin
                $error("status exp %h got %h", exp_r.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    lbf_in_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    lbf_out_t    out_data;

    bridge_scoreboard sb = new();
    bit   idle_on = 1'b1;
    int   wdog = 0;
    logic [47:0] mac_pool [16];

    always #5 clk = ~clk;

    learning_bridge_forwarder dut (.*);

    // receiver side with bursty stalls
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (gap > 0)
            begin
                gap--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 7) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
    end

    always @(posedge clk)
        if (wdog >= WDOG_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end

    // valid stays high after acceptance until the caller idles or sends again
    task automatic send(lbf_in_t t);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(t);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // the block may still be busy on its last transaction
        repeat (2 * ENTRIES + 20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic lbf_in_t mk(logic [1:0] rt, logic [47:0] d, logic [47:0] s,
                                   logic [2:0] p, logic [15:0] len);
        lbf_in_t t;
        t.req_type = rt;
        t.dst_mac = d;
        t.src_mac = s;
        t.in_port = p;
        t.frame_len = len;
        return t;
    endfunction

    function automatic logic [47:0] pick_mac();
        case ($urandom_range(0, 9))
            0: return 48'({$urandom, $urandom});
            1: return sb.own_mac;
            2: return 48'h0;
            3: return mac_pool[$urandom_range(0, 15)] | (48'd1 << GROUP_BIT);
            default: return mac_pool[$urandom_range(0, 15)];
        endcase
    endfunction

    task automatic random_phase(int n);
        lbf_in_t t;
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            t = mk(k < 70 ? REQ_RX : k < 85 ? REQ_TX : k < 96 ? REQ_TICK : REQ_FLUSH,
                   pick_mac(), pick_mac(), 3'($urandom_range(0, 7)),
                   $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 13))
                                               : 16'($urandom));
            if ($urandom_range(0, 30) == 0)
                t.frame_len = 16'hFFFF;
            send(t);
        end
    endtask

    initial
    begin
        lbf_in_t t;
        for (int i = 0; i < 16; i++)
            mac_pool[i] = 48'({$urandom, $urandom}) & 48'hFEFF_FFFF_FFFF;
        mac_pool[15] = 48'hFEFF_FFFF_FFFF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bridge down at reset: drops, tx with no live port
        send(mk(REQ_RX, 48'h1, mac_pool[0], 3'd0, 16'd64));
        send(mk(REQ_TX, mac_pool[0], 48'h0, 3'd0, 16'd0));
        write_reg(REG_BRIDGE_UP, 48'd1);
        write_reg(REG_PORT_PRESENT, 48'h7F);
        write_reg(REG_PORT_UP, 48'hFF);
        write_reg(REG_AGEING, 48'd3);
        write_reg(REG_BRIDGE_MAC, 48'h0000_0000_0000);
        write_reg(REG_BRIDGE_MAC, 48'hFEFF_FFFF_FFFE);
        send(mk(REQ_RX, 48'h1, mac_pool[0], 3'd1, 16'd13));
        send(mk(REQ_RX, 48'h1, mac_pool[0], 3'd7, 16'd64));
        send(mk(REQ_RX, mac_pool[1], mac_pool[0], 3'd1, 16'd14));
        send(mk(REQ_RX, mac_pool[0], mac_pool[1], 3'd2, 16'hFFFF));
        send(mk(REQ_RX, mac_pool[0], mac_pool[2], 3'd1, 16'd64));
        send(mk(REQ_RX, 48'hFFFF_FFFF_FFFF, 48'h0, 3'd0, 16'd64));
        send(mk(REQ_RX, 48'hFEFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF, 3'd3, 16'd64));
        send(mk(REQ_TX, mac_pool[1], 48'h0, 3'd0, 16'd0));
        send(mk(REQ_TX, 48'hFFFF_FFFF_FFFF, 48'h0, 3'd0, 16'd0));
        for (int i = 0; i < 5; i++)
            send(mk(REQ_TICK, '0, '0, 3'd0, '0));
        send(mk(REQ_RX, mac_pool[1], mac_pool[3], 3'd4, 16'd64));
        send(mk(REQ_FLUSH, '0, '0, 3'd1, '0));
        send(mk(REQ_TX, mac_pool[0], 48'h0, 3'd5, 16'd0));
        write_reg(REG_PORT_UP, 48'h0F);
        send(mk(REQ_RX, mac_pool[3], mac_pool[4], 3'd6, 16'd64));
        send(mk(REQ_TX, mac_pool[4], 48'h0, 3'd0, 16'd0));
        write_reg(REG_PORT_PRESENT, 48'hFF);
        write_reg(REG_AGEING, 48'hFF_FFFF);

        // fill the table past capacity so the oldest entry is replaced
        for (int i = 0; i < ENTRIES + 4; i++)
        begin
            send(mk(REQ_RX, mac_pool[0], 48'h0000_1000_0000 + 48'(i), 3'(i), 16'd64));
            if (i % 8 == 0)
                send(mk(REQ_TICK, '0, '0, 3'd0, '0));
        end

        random_phase(300);
        write_reg(REG_AGEING, 48'd0);
        write_reg(REG_PORT_UP, 48'hA5);
        write_reg(REG_BRIDGE_MAC, {32'd0, mac_pool[5][15:0]} | mac_pool[5]);
        random_phase(250);
        write_reg(REG_AGEING, 48'd40);
        write_reg(REG_PORT_UP, 48'hFF);
        write_reg(REG_PORT_PRESENT, 48'h00);
        random_phase(50);
        write_reg(REG_PORT_PRESENT, 48'hFF);
        write_reg(REG_BRIDGE_UP, 48'd0);
        random_phase(40);
        write_reg(REG_BRIDGE_UP, 48'd1);
        random_phase(200);
        idle_on = 1'b0;
        random_phase(100);
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2 * ENTRIES + 20) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
